// ----- hw/rtl/running_mean_baseline_requantizer_unit_assert.svh -----
// Assertion macros for the running mean baseline requantizer.
// Included by the top level; the bodies are empty when SYNTH is defined.
`ifndef RUNNING_MEAN_BASELINE_REQUANTIZER_UNIT_ASSERT_SVH
`define RUNNING_MEAN_BASELINE_REQUANTIZER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Condition must never hold at a clock edge outside reset.
`define RMBRQ_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
// Antecedent implies consequent in the same cycle.
`define RMBRQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the following cycle.
`define RMBRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMBRQ_ASSERT_NEVER(lbl, cond, msg)
`define RMBRQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define RMBRQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/rmbrq_pkg.sv -----
// Shared constants and register codes for the running mean baseline requantizer.
// No dependencies; imported by the top level.
package rmbrq_pkg;

    localparam int NCHAN      = 64;
    localparam int WINDOW_MAX = 128;

    localparam int CH_W       = $clog2(NCHAN);
    localparam int NCH_W      = $clog2(NCHAN + 1);
    localparam int POS_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SLOT_W     = CH_W + POS_W;
    localparam int RING_DEPTH = NCHAN * WINDOW_MAX;

    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = 32;
    localparam int RECIP_W    = 16;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int WLEN_W     = 8;
    localparam int CIU_W      = 7;
    localparam int BYTE_W     = 8;
    localparam int FCH_W      = 6;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_QUANT_MODE    = 3'd0,
        REG_OUTPUT_OFFSET = 3'd1,
        REG_WINDOW_LEN    = 3'd2,
        REG_WINDOW_RECIP  = 3'd3,
        REG_BIT_THRESHOLD = 3'd4,
        REG_CHANNELS      = 3'd5
    } t_reg_idx;

    typedef enum logic {
        QMODE_BYTE = 1'b0,
        QMODE_BIT  = 1'b1
    } t_qmode;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [FCH_W-1:0]  first_channel;
    } t_result;

endpackage

// ----- hw/rtl/running_mean_baseline_requantizer_unit.sv -----
// Running mean baseline subtraction and requantisation of filterbank samples.
// Depends on rmbrq_pkg and running_mean_baseline_requantizer_unit_assert.svh.
//
//  Channel   Dir  Handshake                   Payload (lowest bit up)
//  s_axis    in   s_axis_tvalid/tready        channel[5:0], sample[29:6]
//  m_axis    out  m_axis_tvalid/tready        out_byte[7:0], first_channel[13:8]
//  apb       in   psel, penable, pwrite       registers at 4*index, pready tied high
//
// One beat is taken per cycle while s_axis_tready is high; a result passes through
// the ring/sum memory read, the sum update, the multiplier and the output stage.
// After reset a clearing pass writes zero to all 8192 ring entries and the 64 sums,
// one entry a cycle, with s_axis_tready low; APB writes are taken.
// Results queue in an eight-entry FIFO; outside the clearing pass s_axis_tready drops only
// when the FIFO and the beats still in the pipeline could fill it, so a stalled m_axis never loses a result.
`include "running_mean_baseline_requantizer_unit_assert.svh"

module running_mean_baseline_requantizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis_tdata: channel[5:0], sample[29:6], zero [31:30]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // m_axis_tdata: out_byte[7:0], first_channel[13:8], zero [15:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rmbrq_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                r_quant_mode;
    logic [BYTE_W-1:0]   r_output_offset;
    logic [WLEN_W-1:0]   r_window_len;
    logic [RECIP_W-1:0]  r_window_recip;
    logic [SAMPLE_W-1:0] r_bit_threshold;
    logic [CIU_W-1:0]    r_channels;

    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_mode    <= QMODE_BYTE;
            r_output_offset <= 8'd128;
            r_window_len    <= 8'd100;
            r_window_recip  <= 16'd655;
            r_bit_threshold <= '0;
            r_channels      <= 7'd64;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_QUANT_MODE:    r_quant_mode    <= pwdata[0];
                REG_OUTPUT_OFFSET: r_output_offset <= pwdata[BYTE_W-1:0];
                REG_WINDOW_LEN:    r_window_len    <= pwdata[WLEN_W-1:0];
                REG_WINDOW_RECIP:  r_window_recip  <= pwdata[RECIP_W-1:0];
                REG_BIT_THRESHOLD: r_bit_threshold <= pwdata[SAMPLE_W-1:0];
                REG_CHANNELS:      r_channels      <= pwdata[CIU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_QUANT_MODE:    prdata = {31'd0, r_quant_mode};
            REG_OUTPUT_OFFSET: prdata = {24'd0, r_output_offset};
            REG_WINDOW_LEN:    prdata = {24'd0, r_window_len};
            REG_WINDOW_RECIP:  prdata = {16'd0, r_window_recip};
            REG_BIT_THRESHOLD: prdata = {8'd0, r_bit_threshold};
            REG_CHANNELS:      prdata = {25'd0, r_channels};
            default:           prdata = '0;
        endcase
    end

    // Effective channel count and window length: zero counts as one, clamp to the maximum
    logic [CIU_W-1:0]  nch_eff;
    logic [WLEN_W-1:0] wlen_eff;

    always_comb begin
        if (r_channels == '0)
            nch_eff = CIU_W'(1);
        else if (r_channels > CIU_W'(NCHAN))
            nch_eff = CIU_W'(NCHAN);
        else
            nch_eff = r_channels;
        if (r_window_len == '0)
            wlen_eff = WLEN_W'(1);
        else if (r_window_len > WLEN_W'(WINDOW_MAX))
            wlen_eff = WLEN_W'(WINDOW_MAX);
        else
            wlen_eff = r_window_len;
    end

    // ------------------------------------------------------------------
    // State memories: history ring and per-channel running sum
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [SUM_W-1:0]    sum_mem  [NCHAN];

    logic [SAMPLE_W-1:0] r_ring_rd;
    logic [SUM_W-1:0]    r_sum_rd;

    // Clearing pass after reset
    logic              r_clr_busy;
    logic [SLOT_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + SLOT_W'(1);
            if (r_clr_addr == SLOT_W'(RING_DEPTH - 1))
                r_clr_busy <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: decode the beat, form the ring slot, advance the position
    // ------------------------------------------------------------------
    logic [CH_W-1:0]     in_ch;
    logic [SAMPLE_W-1:0] in_smp;
    logic                in_acc;
    logic                in_used;
    logic                in_last;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    pos_eff;
    logic [WLEN_W-1:0]   pos_inc;
    logic [SLOT_W-1:0]   in_slot;

    assign in_ch   = s_axis_tdata[CH_W-1:0];
    assign in_smp  = s_axis_tdata[CH_W +: SAMPLE_W];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_used = CIU_W'(in_ch) < nch_eff;
    assign in_last = CIU_W'(in_ch) == (nch_eff - CIU_W'(1));
    assign pos_eff = (WLEN_W'(r_pos) < wlen_eff) ? r_pos : '0;
    assign pos_inc = WLEN_W'(pos_eff) + WLEN_W'(1);
    assign in_slot = {in_ch, pos_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (in_acc && in_used && in_last) begin
            r_pos <= (pos_inc >= wlen_eff) ? '0 : pos_inc[POS_W-1:0];
        end
    end

    // Read both memories at the accepting edge
    always_ff @(posedge i_clk) begin
        r_ring_rd <= ring_mem[in_slot];
        r_sum_rd  <= sum_mem[in_ch];
    end

    // ------------------------------------------------------------------
    // Stage 1: update the sum, write back ring and sum
    // ------------------------------------------------------------------
    logic                r_s1_valid;
    logic [CH_W-1:0]     r_s1_ch;
    logic [SAMPLE_W-1:0] r_s1_smp;
    logic [SLOT_W-1:0]   r_s1_slot;
    logic                r_s1_last;

    // Last write-back, held to forward into a read taken at the same edge
    logic                r_fw_valid;
    logic [CH_W-1:0]     r_fw_ch;
    logic [SLOT_W-1:0]   r_fw_slot;
    logic [SAMPLE_W-1:0] r_fw_smp;
    logic [SUM_W-1:0]    r_fw_sum;

    logic [SAMPLE_W-1:0] s1_old;
    logic [SUM_W-1:0]    s1_sum_old;
    logic [SUM_W-1:0]    n_sum;

    always_comb begin
        s1_old     = (r_fw_valid && r_fw_slot == r_s1_slot) ? r_fw_smp : r_ring_rd;
        s1_sum_old = (r_fw_valid && r_fw_ch == r_s1_ch) ? r_fw_sum : r_sum_rd;
        n_sum      = s1_sum_old + SUM_W'(signed'(r_s1_smp)) - SUM_W'(signed'(s1_old));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc && in_used;
            r_fw_valid <= r_s1_valid;
        end
        r_s1_ch   <= in_ch;
        r_s1_smp  <= in_smp;
        r_s1_slot <= in_slot;
        r_s1_last <= in_last;
        r_fw_ch   <= r_s1_ch;
        r_fw_slot <= r_s1_slot;
        r_fw_smp  <= r_s1_smp;
        r_fw_sum  <= n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            ring_mem[r_s1_slot] <= r_s1_smp;
            sum_mem[r_s1_ch]    <= n_sum;
        end else if (r_clr_busy) begin
            ring_mem[r_clr_addr]         <= '0;
            sum_mem[r_clr_addr[CH_W-1:0]] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: multiply the sum by the reciprocal
    // ------------------------------------------------------------------
    logic                r_s2_valid;
    logic [CH_W-1:0]     r_s2_ch;
    logic [SAMPLE_W-1:0] r_s2_smp;
    logic                r_s2_last;
    logic [SUM_W-1:0]    r_s2_sum;

    logic signed [PROD_W:0] s2_prod;

    assign s2_prod = signed'(r_s2_sum) * signed'({1'b0, r_window_recip});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s2_valid <= 1'b0;
        else
            r_s2_valid <= r_s1_valid;
        r_s2_ch   <= r_s1_ch;
        r_s2_smp  <= r_s1_smp;
        r_s2_last <= r_s1_last;
        r_s2_sum  <= n_sum;
    end

    // ------------------------------------------------------------------
    // Stage 3: subtract the mean, requantise or pack decision bits
    // ------------------------------------------------------------------
    logic                r_s3_valid;
    logic [CH_W-1:0]     r_s3_ch;
    logic [SAMPLE_W-1:0] r_s3_smp;
    logic                r_s3_last;
    logic [PROD_W-1:0]   r_s3_prod;
    logic [BYTE_W-1:0]   r_pack;

    logic signed [SUM_W-1:0]  s3_mean;
    logic signed [SUM_W+1:0]  s3_val;
    logic signed [SUM_W+1:0]  s3_diff;
    logic [BYTE_W-1:0]        s3_base;
    logic [BYTE_W-1:0]        s3_bits;
    logic                     s3_emit;
    logic                     s3_has_res;
    t_result                  s3_res;

    always_comb begin
        // floor(prod / 65536) in both signs
        s3_mean = signed'(r_s3_prod[PROD_W-1:RECIP_W]);
        s3_val  = (SUM_W+2)'(signed'(r_s3_smp))
                + signed'((SUM_W+2)'({r_output_offset, 8'd0}))
                - (SUM_W+2)'(s3_mean);
        s3_diff = (SUM_W+2)'(signed'(r_s3_smp)) - (SUM_W+2)'(s3_mean);
        s3_base = (r_s3_ch[2:0] == 3'd0) ? '0 : r_pack;
        s3_bits = s3_base;
        if (s3_diff > (SUM_W+2)'(signed'(r_bit_threshold)))
            s3_bits = s3_base | (8'h80 >> r_s3_ch[2:0]);
        s3_emit = (r_s3_ch[2:0] == 3'd7) || r_s3_last;

        if (r_quant_mode == QMODE_BYTE) begin
            s3_has_res = r_s3_valid;
            s3_res.first_channel = FCH_W'(r_s3_ch);
            if (s3_val < 0)
                s3_res.out_byte = '0;
            else if (s3_val[SUM_W+1:16] != '0)
                s3_res.out_byte = 8'hFF;
            else
                s3_res.out_byte = s3_val[15:8];
        end else begin
            s3_has_res = r_s3_valid && s3_emit;
            s3_res.first_channel = FCH_W'({r_s3_ch[CH_W-1:3], 3'd0});
            s3_res.out_byte      = s3_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_pack     <= '0;
        end else begin
            r_s3_valid <= r_s2_valid;
            if (r_s3_valid && r_quant_mode == QMODE_BIT)
                r_pack <= s3_emit ? '0 : s3_bits;
        end
        r_s3_ch   <= r_s2_ch;
        r_s3_smp  <= r_s2_smp;
        r_s3_last <= r_s2_last;
        r_s3_prod <= s2_prod[PROD_W-1:0];
    end

    // ------------------------------------------------------------------
    // Result FIFO and input flow control
    // ------------------------------------------------------------------
    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  fifo_push;
    logic                  fifo_pop;
    logic [FIFO_CNT_W-1:0] committed;
    t_result               head;

    assign fifo_push = s3_has_res;
    assign fifo_pop  = m_axis_tvalid && m_axis_tready;
    // Count every beat still in the pipeline as a future result
    assign committed = r_cnt + FIFO_CNT_W'(r_s1_valid) + FIFO_CNT_W'(r_s2_valid)
                     + FIFO_CNT_W'(r_s3_valid);

    assign s_axis_tready = !r_clr_busy && (committed < FIFO_CNT_W'(FIFO_DEPTH));
    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = r_cnt != '0;
    assign m_axis_tdata  = {2'b00, head.first_channel, head.out_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (fifo_push)
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            if (fifo_pop)
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            case ({fifo_push, fifo_pop})
                2'b10:   r_cnt <= r_cnt + FIFO_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - FIFO_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fifo_push)
            r_fifo[r_wr_ptr] <= s3_res;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RMBRQ_ASSERT_NEVER(a_fifo_overflow, fifo_push && !fifo_pop && r_cnt == FIFO_CNT_W'(FIFO_DEPTH), "result FIFO overflow")
    `RMBRQ_ASSERT_NEVER(a_commit_bound, committed > FIFO_CNT_W'(FIFO_DEPTH), "more beats in flight than FIFO space")
    `RMBRQ_ASSERT_IMPL(a_no_wb_in_clear, r_clr_busy, !r_s1_valid && !r_s2_valid && !r_s3_valid, "pipeline active during clearing pass")
    `RMBRQ_ASSERT_NEXT(a_fw_follows_wb, r_s1_valid, r_fw_valid && r_fw_sum == $past(n_sum), "forwarding register missed a write-back")

endmodule
